[sv/npc_pkg.sv]
package npc_pkg;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         proto_index;
    logic signed [31:0] invariant_feature;
    logic signed [31:0] area_feature;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  class_index;
    logic        is_unknown;
    logic [15:0] class_count;
  } out_item_t;

  // action codes
  localparam logic [1:0] ACT_CLASSIFY = 2'd0;
  localparam logic [1:0] ACT_LOAD     = 2'd1;
  localparam logic [1:0] ACT_CLEAR    = 2'd2;

  // register indexes
  localparam logic [1:0] REG_INV_WEIGHT  = 2'd0;
  localparam logic [1:0] REG_AREA_WEIGHT = 2'd1;
  localparam logic [1:0] REG_DIST_LIMIT  = 2'd2;

  localparam int REG_W   = 16;
  localparam int FEAT_W  = 32;
  // weighted score: two 80-bit terms, Q49.32
  localparam int SCORE_W = 81;

  localparam logic [REG_W-1:0] INV_WEIGHT_RST  = 16'd10000;
  localparam logic [REG_W-1:0] AREA_WEIGHT_RST = 16'd100;
  localparam logic [REG_W-1:0] DIST_LIMIT_RST  = 16'd300;

endpackage

[sv/npc_ram.sv]
module npc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/npc_mul.sv]
module npc_mul import npc_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [FEAT_W-1:0]     a,
  input  logic [FEAT_W-1:0]     b,
  output logic [2*FEAT_W-1:0]   p
);

  // shared unsigned multiplier, product registered
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

[sv/nearest_prototype_classifier_core.sv]
// Nearest-prototype classifier with reject.
// Input channel (in_valid/in_ready/in_data) carries three kinds of item:
//   classify: scores the feature pair against every prototype slot and
//     returns one result item (class, unknown flag, updated class count);
//   load: writes one prototype slot if the index is in range, no result;
//   clear: zeroes all class counters, no result.
// Config port (cfg_we/cfg_index/cfg_data) writes the two weights and the
// reject limit; write only while the block is idle.
// Load and clear items are done on acceptance. A classify item walks the
// prototype slots one at a time through a single 32x32 multiplier: per
// slot it squares and weights the invariant and the area distance, adds
// and compares; then come the reject decision and counter update.
// in_ready is high only while no item is in progress.
// The result sits in an output register; the next item is accepted while it
// waits. A classify item that finishes while the result is still stalled
// holds until out_ready frees the register.
// Reset (synchronous, rst high) restores the default weights and limit, and
// makes all prototypes and counters read as zero.
module nearest_prototype_classifier_core import npc_pkg::*; #(
  parameter int NUM_PROTOTYPES = 9,
  parameter int COUNT_WIDTH    = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(NUM_PROTOTYPES + 1);
  localparam int PA_W  = (NUM_PROTOTYPES > 1) ? $clog2(NUM_PROTOTYPES) : 1;
  localparam int NCLS  = NUM_PROTOTYPES + 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQI  = 4'd1;
  localparam logic [3:0] ST_WIL  = 4'd2;
  localparam logic [3:0] ST_WIH  = 4'd3;
  localparam logic [3:0] ST_SQA  = 4'd4;
  localparam logic [3:0] ST_WAL  = 4'd5;
  localparam logic [3:0] ST_WAH  = 4'd6;
  localparam logic [3:0] ST_ACC  = 4'd7;
  localparam logic [3:0] ST_CMP  = 4'd8;
  localparam logic [3:0] ST_DEC  = 4'd9;
  localparam logic [3:0] ST_CNT  = 4'd10;

  logic [3:0] state, state_next;

  logic [REG_W-1:0] inv_weight, area_weight, dist_limit;
  logic [FEAT_W-1:0] feat_inv, feat_area;

  logic [IDX_W-1:0] idx, best_idx, cls;
  logic [SCORE_W-1:0] score, best_score;
  logic [FEAT_W-1:0] sq_hi, area_mag;
  logic unknown;

  logic [NUM_PROTOTYPES-1:0] proto_valid;
  logic [NCLS-1:0] count_valid;
  logic pvalid_rd, cvalid_rd;

  logic in_fire, is_last, out_load;

  // prototype memory
  logic               proto_we, proto_rd_en;
  logic [PA_W-1:0]    proto_wr_addr, proto_rd_addr;
  logic [2*FEAT_W-1:0] proto_rd_data;

  // counter memory
  logic                    cnt_we, cnt_rd_en;
  logic [IDX_W-1:0]        cls_next;
  logic [COUNT_WIDTH-1:0]  cnt_rd_data, cnt_cur, cnt_new;

  // multiplier
  logic                  mul_en;
  logic [FEAT_W-1:0]     mul_a, mul_b;
  logic [2*FEAT_W-1:0]   prod;

  logic [FEAT_W:0]   inv_diff, area_diff;
  logic [FEAT_W-1:0] inv_mag, area_mag_next, p_inv, p_area;
  logic              unknown_next;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign is_last  = (idx == IDX_W'(NUM_PROTOTYPES - 1));
  assign out_load = (state == ST_CNT) && (!out_valid || out_ready);

  // ---- prototype read/write ----
  assign proto_we      = in_fire && (in_data.action == ACT_LOAD) &&
                         (32'(in_data.proto_index) < NUM_PROTOTYPES);
  assign proto_wr_addr = PA_W'(in_data.proto_index);
  assign proto_rd_en   = (in_fire && (in_data.action == ACT_CLASSIFY)) ||
                         ((state == ST_CMP) && !is_last);
  assign proto_rd_addr = (state == ST_IDLE) ? '0 : PA_W'(IDX_W'(idx + 1'b1));

  npc_ram #(.WIDTH(2 * FEAT_W), .DEPTH(NUM_PROTOTYPES)) u_proto_ram (
    .clk     (clk),
    .we      (proto_we),
    .wr_addr (proto_wr_addr),
    .wr_data ({in_data.invariant_feature, in_data.area_feature}),
    .rd_en   (proto_rd_en),
    .rd_addr (proto_rd_addr),
    .rd_data (proto_rd_data)
  );

  // never-loaded slots read as zero
  assign p_inv  = pvalid_rd ? proto_rd_data[2*FEAT_W-1:FEAT_W] : '0;
  assign p_area = pvalid_rd ? proto_rd_data[FEAT_W-1:0] : '0;

  assign inv_diff  = {feat_inv[FEAT_W-1], feat_inv} - {p_inv[FEAT_W-1], p_inv};
  assign area_diff = {feat_area[FEAT_W-1], feat_area} - {p_area[FEAT_W-1], p_area};
  assign inv_mag       = inv_diff[FEAT_W] ? FEAT_W'(-inv_diff) : FEAT_W'(inv_diff);
  assign area_mag_next = area_diff[FEAT_W] ? FEAT_W'(-area_diff) : FEAT_W'(area_diff);

  // ---- shared multiplier schedule ----
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      ST_SQI: begin
        mul_a = inv_mag;
        mul_b = inv_mag;
      end
      ST_WIL: begin
        mul_a = prod[FEAT_W-1:0];
        mul_b = FEAT_W'(inv_weight);
      end
      ST_WIH: begin
        mul_a = sq_hi;
        mul_b = FEAT_W'(inv_weight);
      end
      ST_SQA: begin
        mul_a = area_mag;
        mul_b = area_mag;
      end
      ST_WAL: begin
        mul_a = prod[FEAT_W-1:0];
        mul_b = FEAT_W'(area_weight);
      end
      ST_WAH: begin
        mul_a = sq_hi;
        mul_b = FEAT_W'(area_weight);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  npc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // ---- decision and counters ----
  assign unknown_next = best_score > SCORE_W'({dist_limit, 32'b0});
  assign cls_next     = unknown_next ? IDX_W'(NUM_PROTOTYPES) : best_idx;
  assign cnt_rd_en    = (state == ST_DEC);
  assign cnt_we       = out_load;
  assign cnt_cur      = cvalid_rd ? cnt_rd_data : '0;
  assign cnt_new      = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;

  npc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NCLS)) u_count_ram (
    .clk     (clk),
    .we      (cnt_we),
    .wr_addr (cls),
    .wr_data (cnt_new),
    .rd_en   (cnt_rd_en),
    .rd_addr (cls_next),
    .rd_data (cnt_rd_data)
  );

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire && in_data.action == ACT_CLASSIFY) state_next = ST_SQI;
      ST_SQI:  state_next = ST_WIL;
      ST_WIL:  state_next = ST_WIH;
      ST_WIH:  state_next = ST_SQA;
      ST_SQA:  state_next = ST_WAL;
      ST_WAL:  state_next = ST_WAH;
      ST_WAH:  state_next = ST_ACC;
      ST_ACC:  state_next = ST_CMP;
      ST_CMP:  state_next = is_last ? ST_DEC : ST_SQI;
      ST_DEC:  state_next = ST_CNT;
      ST_CNT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      inv_weight  <= INV_WEIGHT_RST;
      area_weight <= AREA_WEIGHT_RST;
      dist_limit  <= DIST_LIMIT_RST;
      proto_valid <= '0;
      count_valid <= '0;
      out_valid   <= 1'b0;
      idx         <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INV_WEIGHT:  inv_weight  <= cfg_data;
          REG_AREA_WEIGHT: area_weight <= cfg_data;
          REG_DIST_LIMIT:  dist_limit  <= cfg_data;
          default: ;
        endcase
      end
      if (proto_we) proto_valid[proto_wr_addr] <= 1'b1;
      if (in_fire && in_data.action == ACT_CLEAR) begin
        count_valid <= '0;
      end else if (cnt_we) begin
        count_valid[cls] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        idx <= '0;
      end else if (state == ST_CMP && !is_last) begin
        idx <= IDX_W'(idx + 1'b1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      feat_inv  <= in_data.invariant_feature;
      feat_area <= in_data.area_feature;
    end
    if (proto_rd_en) pvalid_rd <= proto_valid[proto_rd_addr];
    unique case (state)
      ST_SQI: area_mag <= area_mag_next;
      ST_WIL: sq_hi <= prod[2*FEAT_W-1:FEAT_W];
      ST_WIH: score <= SCORE_W'(prod[47:0]);
      ST_SQA: score <= score + SCORE_W'({prod[47:0], 32'b0});
      ST_WAL: sq_hi <= prod[2*FEAT_W-1:FEAT_W];
      ST_WAH: score <= score + SCORE_W'(prod[47:0]);
      ST_ACC: score <= score + SCORE_W'({prod[47:0], 32'b0});
      ST_CMP: begin
        // strict less: lowest index wins a tie
        if (idx == '0 || score < best_score) begin
          best_score <= score;
          best_idx   <= idx;
        end
      end
      ST_DEC: begin
        cls       <= cls_next;
        unknown   <= unknown_next;
        cvalid_rd <= count_valid[cls_next];
      end
      default: ;
    endcase
    if (out_load) begin
      out_data.class_index <= 4'(cls);
      out_data.is_unknown  <= unknown;
      out_data.class_count <= 16'(cnt_new);
    end
  end

  // ---- assertions ----
  a_unknown_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_unknown |-> out_data.class_index == 4'(NUM_PROTOTYPES))
    else $error("unknown result with wrong class index");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> 32'(idx) < NUM_PROTOTYPES)
    else $error("prototype walk index out of range");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.class_count != '0 || COUNT_WIDTH > 16))
    else $error("reported class count is zero");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_CNT)
    else $error("result raised outside counter update");

endmodule

[bench/tb.sv]
module tb;
  import npc_pkg::*;

  localparam int NPROTO        = 9;
  localparam int SETTLE_CYCLES = 90;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 176;
  localparam int DIRECTED_ROWS = 29;

  localparam logic [1:0]  ACT_NOP  = 2'd3;  // unused action code, dropped by the block
  localparam logic [1:0]  REG_NONE = 2'd3;  // index past the register list
  localparam logic [31:0] FMAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] FMIN     = 32'h8000_0000;
  localparam logic [31:0] FAR      = 32'h4000_0000;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  // cfg rows: code is the register index, inv carries the value
  typedef struct {
    row_kind_e   kind;
    logic [1:0]  code;
    logic [3:0]  slot;
    logic [31:0] inv;
    logic [31:0] area;
    bit          typed;
    logic [3:0]  cls;
    bit          unk;
    logic [15:0] cnt;
  } step_t;

  typedef struct packed {
    logic [15:0] wi;
    logic [15:0] wa;
    logic [15:0] lim;
  } cfg_set_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [REG_W-1:0] cfg_data  = '0;

  // classifier state as the testbench sees it
  logic [31:0] proto_inv_q  [NPROTO];
  logic [31:0] proto_area_q [NPROTO];
  logic [15:0] hit_count    [NPROTO+1];
  logic [15:0] w_inv, w_area, reject_lim;

  out_item_t expected_labels[$];
  out_item_t expected_label;

  int  errors;
  int  n_items;
  int  n_results;
  int  n_unknown;
  int  n_reg_writes;
  int  quiet;
  bit  steady;

  step_t plan [DIRECTED_ROWS];

  nearest_prototype_classifier_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("label %0d: %s is %0d, expected %0d", n_results, what, got, want);
  endtask

  // weighted squared distance to one prototype, full 81-bit width
  function automatic logic [80:0] weighted_dist(in_item_t it, int s);
    logic [32:0] di, da, mi, ma;
    logic [80:0] si, sa;
    di = {it.invariant_feature[31], it.invariant_feature} - {proto_inv_q[s][31], proto_inv_q[s]};
    da = {it.area_feature[31], it.area_feature} - {proto_area_q[s][31], proto_area_q[s]};
    // magnitudes taken at 33 bits so the negate does not see the wide context
    mi = di[32] ? -di : di;
    ma = da[32] ? -da : da;
    si = 81'(mi);
    sa = 81'(ma);
    si = si * si * w_inv;
    sa = sa * sa * w_area;
    return si + sa;
  endfunction

  task automatic predict_item(input in_item_t it, output bit produced, output out_item_t label);
    logic [80:0] best_d, d;
    logic [3:0]  best_i, cls;
    bit          unk;
    produced = 1'b0;
    label    = '0;
    case (it.action)
      ACT_LOAD: begin
        if (it.proto_index < NPROTO) begin
          proto_inv_q[it.proto_index]  = it.invariant_feature;
          proto_area_q[it.proto_index] = it.area_feature;
        end
      end
      ACT_CLEAR: begin
        foreach (hit_count[i]) hit_count[i] = '0;
      end
      ACT_CLASSIFY: begin
        best_i = '0;
        best_d = weighted_dist(it, 0);
        for (int i = 1; i < NPROTO; i++) begin
          d = weighted_dist(it, i);
          // strict compare: lowest slot keeps a tie
          if (d < best_d) begin
            best_d = d;
            best_i = 4'(i);
          end
        end
        unk = best_d > {33'd0, reject_lim, 32'd0};
        cls = unk ? 4'(NPROTO) : best_i;
        if (hit_count[cls] != 16'hFFFF) hit_count[cls]++;
        produced          = 1'b1;
        label.class_index = cls;
        label.is_unknown  = unk;
        label.class_count = hit_count[cls];
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] jitter();
    int unsigned k;
    logic [31:0] v;
    k = $urandom_range(0, 24);
    v = $urandom & ((32'd1 << k) - 32'd1);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic next_random_item(output in_item_t it, output bit effective);
    int pick, sel, s;
    pick                 = $urandom_range(0, 99);
    it.proto_index       = 4'($urandom_range(0, 15));
    it.invariant_feature = $urandom;
    it.area_feature      = $urandom;
    effective            = 1'b1;
    if (pick < 70) begin
      it.action = ACT_CLASSIFY;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        // near a stored prototype so both sides of the limit get hit
        s = $urandom_range(0, NPROTO - 1);
        it.invariant_feature = proto_inv_q[s] + jitter();
        it.area_feature      = proto_area_q[s] + jitter();
      end else if (sel < 80) begin
        it.invariant_feature = jitter();
        it.area_feature      = jitter();
      end
    end else if (pick < 90) begin
      it.action      = ACT_LOAD;
      it.proto_index = 4'($urandom_range(0, NPROTO - 1));
      if ($urandom_range(0, 1)) begin
        it.invariant_feature = jitter();
        it.area_feature      = jitter();
      end
    end else if (pick < 93) begin
      it.action      = ACT_LOAD;
      it.proto_index = 4'($urandom_range(NPROTO, 15));
      effective      = 1'b0;
    end else if (pick < 96) begin
      it.action = ACT_CLEAR;
    end else begin
      it.action = ACT_NOP;
      effective = 1'b0;
    end
  endtask

  // returns at the accepting edge with in_valid still high
  task automatic push_item(in_item_t it, bit typed, out_item_t typed_label);
    int        gap;
    bit        produced;
    out_item_t label;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 19) gap = $urandom_range(1, 90);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    predict_item(it, produced, label);
    if (produced) expected_labels.push_back(typed ? typed_label : label);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_labels.size() != 0) @(posedge clk);
    // a trailing load or clear leaves no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    n_reg_writes++;
    case (idx)
      REG_INV_WEIGHT:  w_inv      = val;
      REG_AREA_WEIGHT: w_area     = val;
      REG_DIST_LIMIT:  reject_lim = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (out_data.is_unknown) n_unknown++;
      if (expected_labels.size() == 0) begin
        report_mismatch("result with nothing pending, class_index", out_data.class_index, 0);
      end else begin
        expected_label = expected_labels.pop_front();
        if (out_data.class_index !== expected_label.class_index)
          report_mismatch("class_index", out_data.class_index, expected_label.class_index);
        if (out_data.is_unknown !== expected_label.is_unknown)
          report_mismatch("is_unknown", out_data.is_unknown, expected_label.is_unknown);
        if (out_data.class_count !== expected_label.class_count)
          report_mismatch("class_count", out_data.class_count, expected_label.class_count);
      end
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d labels pending",
               STALL_LIMIT, expected_labels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    out_ready <= steady || ($urandom_range(0, 99) >= 19);
  end

  initial begin
    in_item_t  it;
    out_item_t want;
    bit        eff;
    bit        cfg_open;
    int        cnt;
    cfg_set_t  phases [6];

    w_inv      = INV_WEIGHT_RST;
    w_area     = AREA_WEIGHT_RST;
    reject_lim = DIST_LIMIT_RST;
    foreach (proto_inv_q[i]) proto_inv_q[i] = '0;
    foreach (proto_area_q[i]) proto_area_q[i] = '0;
    foreach (hit_count[i]) hit_count[i] = '0;
    cfg_open = 1'b0;

    plan = '{
      '{ROW_ITEM, ACT_CLASSIFY, 4'd0,  32'h0, 32'h0, 1'b1, 4'd0, 1'b0, 16'd1},
      '{ROW_ITEM, ACT_CLASSIFY, 4'd5,  FMAX,  FMAX,  1'b1, 4'd9, 1'b1, 16'd1},
      '{ROW_ITEM, ACT_CLASSIFY, 4'd15, FMIN,  FMIN,  1'b1, 4'd9, 1'b1, 16'd2},
      '{ROW_ITEM, ACT_NOP,      4'd1,  FAR,   FAR,   1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_LOAD,     4'd15, FAR,   FAR,   1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_LOAD,     4'd9,  FAR,   FAR,   1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_LOAD,     4'd0,  FMAX,  FMAX,  1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_LOAD,     4'd8,  FMIN,  FMIN,  1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_CLASSIFY, 4'd3,  FMAX,  FMAX,  1'b1, 4'd0, 1'b0, 16'd2},
      '{ROW_ITEM, ACT_CLASSIFY, 4'd0,  FMIN,  FMIN,  1'b1, 4'd8, 1'b0, 16'd1},
      // equal scores on slots 1..7: lowest wins
      '{ROW_ITEM, ACT_CLASSIFY, 4'd0,  32'h1, 32'h1, 1'b1, 4'd1, 1'b0, 16'd1},
      '{ROW_ITEM, ACT_CLEAR,    4'd7,  FMAX,  FMIN,  1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_CLASSIFY, 4'd0,  32'h0, 32'h0, 1'b1, 4'd1, 1'b0, 16'd1},
      '{ROW_ITEM, ACT_CLASSIFY, 4'd0,  FMAX,  FMIN,  1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_CFG,  REG_INV_WEIGHT,  4'd0, 32'd1, 32'h0, 1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_CFG,  REG_AREA_WEIGHT, 4'd0, 32'd0, 32'h0, 1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_CFG,  REG_DIST_LIMIT,  4'd0, 32'd1, 32'h0, 1'b0, 4'd0, 1'b0, 16'd0},
      // score exactly at the limit, then one step past it
      '{ROW_ITEM, ACT_CLASSIFY, 4'd0, 32'h0001_0000, FMAX, 1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_CLASSIFY, 4'd0, 32'h0001_0001, FMIN, 1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_CLASSIFY, 4'd0, 32'hFFFF_0000, 32'h0, 1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_CFG,  REG_INV_WEIGHT,  4'd0, 32'd0, 32'h0, 1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_CFG,  REG_DIST_LIMIT,  4'd0, 32'd0, 32'h0, 1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_CLASSIFY, 4'd0, 32'h1357_9BDF, 32'h2468_ACE0,
        1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_CFG,  REG_INV_WEIGHT,  4'd0, 32'hFFFF, 32'h0, 1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_CFG,  REG_AREA_WEIGHT, 4'd0, 32'hFFFF, 32'h0, 1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_CFG,  REG_DIST_LIMIT,  4'd0, 32'hFFFF, 32'h0, 1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_CLASSIFY, 4'd0,  FMIN,  FMAX,  1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_CFG,  REG_NONE,        4'd0, 32'hFFFF, 32'h0, 1'b0, 4'd0, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_CLASSIFY, 4'd0,  FMAX,  FMIN,  1'b0, 4'd0, 1'b0, 16'd0}
    };

    phases = '{
      '{16'd10000, 16'd100,   16'd300},
      '{16'hFFFF,  16'hFFFF,  16'hFFFF},
      '{16'd0,     16'd0,     16'd0},
      '{16'd0,     16'd0,     16'd0},
      '{16'd1,     16'hFFFF,  16'd0},
      '{16'd0,     16'd0,     16'd0}
    };
    phases[3] = {16'($urandom), 16'($urandom), 16'($urandom_range(0, 2000))};
    phases[5] = {16'($urandom), 16'($urandom), 16'($urandom)};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(plan[r].code, plan[r].inv[15:0]);
      end else begin
        if (cfg_open) begin
          cfg_we   <= 1'b0;
          cfg_open = 1'b0;
        end
        it.action            = plan[r].code;
        it.proto_index       = plan[r].slot;
        it.invariant_feature = plan[r].inv;
        it.area_feature      = plan[r].area;
        want.class_index     = plan[r].cls;
        want.is_unknown      = plan[r].unk;
        want.class_count     = plan[r].cnt;
        push_item(it, plan[r].typed, want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(REG_INV_WEIGHT, phases[p].wi);
      write_reg(REG_AREA_WEIGHT, phases[p].wa);
      write_reg(REG_DIST_LIMIT, phases[p].lim);
      cfg_we <= 1'b0;
      steady = (p == 3);
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        next_random_item(it, eff);
        if (eff) cnt++;
        push_item(it, 1'b0, '0);
      end
    end
    steady = 1'b0;

    settle();
    $display("run: %0d items in, %0d labels checked (%0d unknown), %0d register writes",
             n_items, n_results, n_unknown, n_reg_writes);
    $display("     directed edges plus %0d register settings with near-prototype traffic",
             6);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/npc_pkg.sv
sv/npc_ram.sv
sv/npc_mul.sv
sv/nearest_prototype_classifier_core.sv
bench/tb.sv
